// ===== sv/bblc_pkg.sv =====
// Shared constants, types and codes of the byte budget LRU cache directory.
package bblc_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned KEY_WIDTH = 32;

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_PW = 32;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned USED_W = 40;
  localparam int unsigned RAM_W  = KEY_PW + SIZE_W;

  // Keys wider than the key port keep all port bits.
  localparam int unsigned KEY_W = (KEY_WIDTH < KEY_PW) ? KEY_WIDTH : KEY_PW;
  localparam logic [KEY_PW-1:0] KEY_MASK =
    (KEY_W >= KEY_PW) ? {KEY_PW{1'b1}} : KEY_PW'((64'd1 << KEY_W) - 64'd1);

  typedef enum logic [1:0] {
    REQ_FIND   = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_ERASE  = 2'd2
  } req_e;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_REFRESH  = 1'b1;

  typedef struct packed {
    logic             touch;
    logic             drop;
    logic             ins;
    logic [IDX_W-1:0] idx;
  } slot_op_t;

  typedef struct packed {
    logic [ENTRIES-1:0] valid;
    logic [CNT_W-1:0]   count;
    logic [IDX_W-1:0]   oldest;
    logic [IDX_W-1:0]   free_idx;
  } slot_stat_t;

endpackage

// ===== sv/byte_budget_lru_cache.sv =====
// Top level: request sequencer, key and size store, byte counter and result register.
// Sequence: find, erase, unknown and refreshing insert requests scan one key per slot,
// then pass S_ACT and S_STAT; other inserts loop through S_EVCHK, S_EVRD and S_EVOUT once
// per evicted entry before S_INS and S_STAT. The status beat shows in the first cycle after
// busy falls, after any eviction beats; the receiver cannot stall. Throughput: one request at
// a time. Reset empties all slots and clears the byte count, budget, refresh flag and state.
module byte_budget_lru_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [bblc_pkg::USED_W-1:0]   cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic [bblc_pkg::KEY_PW-1:0]   key_tag_i,
  input  logic [bblc_pkg::SIZE_W-1:0]   entry_bytes_i,
  output logic                          out_valid_o,
  output logic                          is_eviction_o,
  output logic [bblc_pkg::KEY_PW-1:0]   evicted_key_o,
  output logic [bblc_pkg::SIZE_W-1:0]   evicted_bytes_o,
  output logic                          found_o,
  output logic                          over_budget_o,
  output logic [bblc_pkg::USED_W-1:0]   used_after_o,
  output logic                          last_o
);
  import bblc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_EVCHK = 3'd3;
  localparam logic [2:0] S_EVRD  = 3'd4;
  localparam logic [2:0] S_EVOUT = 3'd5;
  localparam logic [2:0] S_INS   = 3'd6;
  localparam logic [2:0] S_STAT  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [USED_W-1:0] cap_q;
  logic              refresh_q;
  logic [USED_W-1:0] used_q, used_d;
  logic [1:0]        req_q, req_d;
  logic [KEY_PW-1:0] key_q, key_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [IDX_W:0]    scan_q, scan_d;
  logic [IDX_W-1:0]  prev_q, prev_d;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [SIZE_W-1:0] hit_size_q, hit_size_d;
  logic              full_ev_q, full_ev_d;

  logic              ov_q, ov_d;
  logic              o_ev_q, o_ev_d;
  logic [KEY_PW-1:0] o_key_q, o_key_d;
  logic [SIZE_W-1:0] o_bytes_q, o_bytes_d;
  logic              o_found_q, o_found_d;
  logic              o_over_q, o_over_d;
  logic [USED_W-1:0] o_used_q, o_used_d;
  logic              o_last_q, o_last_d;

  slot_op_t          op;
  slot_stat_t        stat;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [RAM_W-1:0]  ram_rdata;
  logic [KEY_PW-1:0] rd_key;
  logic [SIZE_W-1:0] rd_size;
  logic [SIZE_W-1:0] alu_op;
  logic              alu_sub;
  logic [USED_W-1:0] alu_res;
  logic              alu_gt;

  assign rd_key  = ram_rdata[KEY_PW-1:0];
  assign rd_size = ram_rdata[RAM_W-1:KEY_PW];

  bblc_ram #(
    .WIDTH(RAM_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(stat.free_idx),
    .wdata_i({size_q, key_q}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bblc_slots u_slots (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (op),
    .stat_o(stat)
  );

  bblc_alu u_alu (
    .used_i   (used_q),
    .operand_i(alu_op),
    .sub_i    (alu_sub),
    .cap_i    (cap_q),
    .res_o    (alu_res),
    .gt_o     (alu_gt)
  );

  assign ram_we    = (state_q == S_INS);
  assign ram_raddr = (state_q == S_EVRD) ? stat.oldest : scan_q[IDX_W-1:0];

  always_comb begin
    unique case (state_q)
      S_ACT:   begin alu_op = hit_size_q; alu_sub = 1'b1; end
      S_EVOUT: begin alu_op = rd_size;    alu_sub = 1'b1; end
      S_EVCHK, S_INS: begin alu_op = size_q; alu_sub = 1'b0; end
      default: begin alu_op = '0;         alu_sub = 1'b0; end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    req_d      = req_q;
    key_d      = key_q;
    size_d     = size_q;
    scan_d     = scan_q;
    prev_d     = prev_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_size_d = hit_size_q;
    full_ev_d  = full_ev_q;
    op         = '0;
    ov_d       = 1'b0;
    o_ev_d     = o_ev_q;
    o_key_d    = o_key_q;
    o_bytes_d  = o_bytes_q;
    o_found_d  = o_found_q;
    o_over_d   = o_over_q;
    o_used_d   = o_used_q;
    o_last_d   = o_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d     = req_type_i;
          key_d     = key_tag_i & KEY_MASK;
          size_d    = entry_bytes_i;
          scan_d    = '0;
          hit_d     = 1'b0;
          full_ev_d = 1'b0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        // Read data is registered, so it belongs to the previous scan address; the lowest matching slot wins.
        prev_d = scan_q[IDX_W-1:0];
        if (scan_q != '0 && !hit_q && stat.valid[prev_q] && rd_key == key_q) begin
          hit_d      = 1'b1;
          hit_idx_d  = prev_q;
          hit_size_d = rd_size;
        end
        if (scan_q == (IDX_W + 1)'(ENTRIES)) begin
          state_d = S_ACT;
        end else begin
          scan_d = scan_q + (IDX_W + 1)'(1);
        end
      end
      S_ACT: begin
        op.idx  = hit_idx_q;
        state_d = S_STAT;
        if (req_q == REQ_FIND) begin
          op.touch = hit_q;
        end else if (req_q == REQ_ERASE) begin
          if (hit_q) begin
            op.drop = 1'b1;
            used_d  = alu_res;
          end
        end else if (req_q == REQ_INSERT) begin
          if (hit_q && refresh_q) begin
            op.touch = 1'b1;
          end else begin
            // A replaced entry frees its bytes without an eviction beat.
            if (hit_q) begin
              op.drop = 1'b1;
              used_d  = alu_res;
            end
            state_d = S_EVCHK;
          end
        end
      end
      S_EVCHK: begin
        if (alu_gt && stat.count != '0) begin
          state_d = S_EVRD;
        end else if (stat.count == CNT_W'(ENTRIES)) begin
          full_ev_d = 1'b1;
          state_d   = S_EVRD;
        end else begin
          state_d = S_INS;
        end
      end
      S_EVRD: begin
        state_d = S_EVOUT;
      end
      S_EVOUT: begin
        op.drop   = 1'b1;
        op.idx    = stat.oldest;
        used_d    = alu_res;
        ov_d      = 1'b1;
        o_ev_d    = 1'b1;
        o_key_d   = rd_key;
        o_bytes_d = rd_size;
        o_found_d = 1'b0;
        o_over_d  = 1'b0;
        o_used_d  = '0;
        o_last_d  = 1'b0;
        state_d   = full_ev_q ? S_INS : S_EVCHK;
      end
      S_INS: begin
        op.ins  = 1'b1;
        op.idx  = stat.free_idx;
        used_d  = alu_res;
        state_d = S_STAT;
      end
      S_STAT: begin
        ov_d      = 1'b1;
        o_ev_d    = 1'b0;
        o_key_d   = '0;
        o_bytes_d = '0;
        o_found_d = hit_q;
        o_over_d  = (req_q == REQ_INSERT) && alu_gt;
        o_used_d  = used_q;
        o_last_d  = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cap_q     <= '0;
      refresh_q <= 1'b0;
      used_q    <= '0;
      ov_q      <= 1'b0;
      hit_q     <= 1'b0;
      full_ev_q <= 1'b0;
      scan_q    <= '0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      ov_q      <= ov_d;
      hit_q     <= hit_d;
      full_ev_q <= full_ev_d;
      scan_q    <= scan_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CAPACITY: cap_q     <= cfg_wdata_i;
          CFG_REFRESH:  refresh_q <= cfg_wdata_i[0];
          default:      cap_q     <= cap_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_q      <= key_d;
    size_q     <= size_d;
    prev_q     <= prev_d;
    hit_idx_q  <= hit_idx_d;
    hit_size_q <= hit_size_d;
    o_ev_q     <= o_ev_d;
    o_key_q    <= o_key_d;
    o_bytes_q  <= o_bytes_d;
    o_found_q  <= o_found_d;
    o_over_q   <= o_over_d;
    o_used_q   <= o_used_d;
    o_last_q   <= o_last_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign out_valid_o     = ov_q;
  assign is_eviction_o   = o_ev_q;
  assign evicted_key_o   = o_key_q;
  assign evicted_bytes_o = o_bytes_q;
  assign found_o         = o_found_q;
  assign over_budget_o   = o_over_q;
  assign used_after_o    = o_used_q;
  assign last_o          = o_last_q;

endmodule

// ===== sv/bblc_ram.sv =====
// Generic single write port RAM with a registered read port.
module bblc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bblc_alu.sv =====
// Shared 40-bit add or subtract unit with a compare against the byte budget.
module bblc_alu (
  input  logic [bblc_pkg::USED_W-1:0] used_i,
  input  logic [bblc_pkg::SIZE_W-1:0] operand_i,
  input  logic                        sub_i,
  input  logic [bblc_pkg::USED_W-1:0] cap_i,
  output logic [bblc_pkg::USED_W-1:0] res_o,
  output logic                        gt_o
);
  import bblc_pkg::*;

  logic [USED_W-1:0] op_ext;
  logic [USED_W:0]   sum;
  logic [USED_W-1:0] diff;
  logic [USED_W:0]   res_ext;

  assign op_ext  = {{(USED_W - SIZE_W){1'b0}}, operand_i};
  assign sum     = {1'b0, used_i} + {1'b0, op_ext};
  assign diff    = used_i - op_ext;
  // The add keeps its carry so that the budget compare sees the true sum.
  assign res_ext = sub_i ? {1'b0, diff} : sum;
  assign res_o   = res_ext[USED_W-1:0];
  assign gt_o    = res_ext > {1'b0, cap_i};

endmodule

// ===== sv/bblc_slots.sv =====
// Valid bits and recency ranks of all slots, with the oldest and free slot finders.
module bblc_slots (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bblc_pkg::slot_op_t     op_i,
  output bblc_pkg::slot_stat_t   stat_o
);
  import bblc_pkg::*;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]   age_q [ENTRIES];
  logic [IDX_W-1:0]   age_d [ENTRIES];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   ref_age;
  logic [CNT_W-1:0]   count_m1;
  logic [IDX_W-1:0]   oldest;
  logic [IDX_W-1:0]   free_idx;

  assign ref_age  = age_q[op_i.idx];
  assign count_m1 = count_q - CNT_W'(1);

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      age_d[i] = age_q[i];
      if (op_i.touch && valid_q[i] && age_q[i] < ref_age) begin
        age_d[i] = age_q[i] + IDX_W'(1);
      end
      if (op_i.drop && valid_q[i] && age_q[i] > ref_age) begin
        age_d[i] = age_q[i] - IDX_W'(1);
      end
      if (op_i.ins && valid_q[i]) begin
        age_d[i] = age_q[i] + IDX_W'(1);
      end
    end
    if (op_i.touch || op_i.ins) begin
      age_d[op_i.idx] = '0;
    end
    if (op_i.drop) begin
      valid_d[op_i.idx] = 1'b0;
      count_d = count_m1;
    end
    if (op_i.ins) begin
      valid_d[op_i.idx] = 1'b1;
      count_d = count_q + CNT_W'(1);
    end
  end

  // Ranks of valid slots are always a permutation of 0 to count-1, so at most
  // one slot matches and an OR of the indexes encodes it.
  always_comb begin
    oldest = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_q[i] && age_q[i] == count_m1[IDX_W-1:0]) begin
        oldest = oldest | IDX_W'(i);
      end
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      age_q[i] <= age_d[i];
    end
  end

  assign stat_o.valid    = valid_q;
  assign stat_o.count    = count_q;
  assign stat_o.oldest   = oldest;
  assign stat_o.free_idx = free_idx;

endmodule
